// ----- rtl/core/point_rotation_about_reference_unit_assert.svh -----
// Assertion macros for the point rotation unit.
// Used by point_rotation_about_reference_unit.sv; no other dependencies.
`ifndef POINT_ROTATION_ABOUT_REFERENCE_UNIT_ASSERT_SVH
`define POINT_ROTATION_ABOUT_REFERENCE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PRAU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Delayed implication: the consequent is checked later, at the delay given by n.
`define PRAU_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/prau_pkg.sv -----
// Package for the point rotation unit: widths, item and pipeline types,
// elaboration-time arctangent table and inverse CORDIC gain. No dependencies.
`timescale 1ns / 1ps

package prau_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int ANGLE_WIDTH = 16;
    localparam int STAGES      = 16;

    // Differences are scaled up by GUARD bits; the scaled difference always
    // takes 59 bits, plus room for negation and CORDIC growth.
    localparam int GUARD       = 58 - COORD_WIDTH;
    localparam int XY_W        = 62;
    localparam int Z_W         = ANGLE_WIDTH + 32;
    localparam int R_W         = ANGLE_WIDTH - 2;
    localparam int STAGE_IDX_W = $clog2(STAGES);
    localparam int HI_W        = XY_W - 32;
    localparam int SUM_W       = XY_W + 1;
    localparam int LATENCY     = STAGES + 5;

    localparam logic [32:0] PI_Q30 = 33'h0_C90F_DAA2;
    localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
    localparam logic [ANGLE_WIDTH-1:0] EIGHTH = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 3);

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Quadrant codes after the eighth-turn offset.
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] pivot_x;
        logic signed [COORD_WIDTH-1:0] pivot_y;
        logic        [ANGLE_WIDTH-1:0] turn_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rotated_x;
        logic signed [COORD_WIDTH-1:0] rotated_y;
        logic                          overflow;
    } t_out_item;

    // Data handed from cell to cell along the chain.
    typedef struct packed {
        logic                          valid;
        logic signed [XY_W-1:0]        x;
        logic signed [XY_W-1:0]        y;
        logic signed [Z_W-1:0]         z;
        logic signed [COORD_WIDTH-1:0] pivot_x;
        logic signed [COORD_WIDTH-1:0] pivot_y;
    } t_cell_bus;

    typedef logic [STAGES-1:0][Z_W-1:0] t_atan_tab;

    // Shift-subtract division, elaboration only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q61 radians, odd power series with truncated terms.
    function automatic logic [63:0] atan_q61(input int i);
        logic signed [63:0] sum;
        logic [63:0]        term;
        sum = '0;
        if (i == 0) begin
            return PI_Q60 >> 1;
        end
        for (int k = 0; k < 32; k++) begin
            if (i * (2 * k + 1) <= 61) begin
                term = udiv64(64'd1 << (61 - i * (2 * k + 1)), 64'(2 * k + 1));
                if ((k & 1) != 0) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
        end
        return sum;
    endfunction

    function automatic t_atan_tab build_atan();
        t_atan_tab  tab;
        logic [63:0] full;
        for (int i = 0; i < STAGES; i++) begin
            full   = atan_q61(i) >> (32 - ANGLE_WIDTH);
            tab[i] = full[Z_W-1:0];
        end
        return tab;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] one;
        n   = val;
        res = '0;
        one = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (one > n) begin
                one = one >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (one != '0) begin
                if (n >= res + one) begin
                    n   = n - (res + one);
                    res = (res >> 1) + one;
                end else begin
                    res = res >> 1;
                end
                one = one >> 2;
            end
        end
        return res;
    endfunction

    // 1/K in Q31, rounded, for the given stage count.
    function automatic logic [31:0] inv_gain_q31();
        logic [63:0] k2;
        logic [63:0] kq;
        logic [63:0] quo;
        k2 = 64'd1 << 60;
        for (int i = 0; i < STAGES; i++) begin
            k2 = k2 + (k2 >> (2 * i));
        end
        kq  = isqrt64(k2);
        quo = udiv64((64'd1 << 61) + (kq >> 1), kq);
        return quo[31:0];
    endfunction

    localparam t_atan_tab   ATAN_TAB = build_atan();
    localparam logic [31:0] KINV     = inv_gain_q31();

endpackage

// ----- rtl/core/point_rotation_about_reference_unit.sv -----
// Point rotation about a pivot: prep stage, STAGES CORDIC cells, gain back end.
// Throughput: one item per cycle; every micro-rotation is its own cell register.
// busy stays low and o_done pulses one cycle per item; the receiver cannot stall.
// Reset (i_rst_n, synchronous, active low) clears valid bits; items in flight drop.
// Depends on prau_pkg, prau_prep, prau_cell, prau_gain and the assertion header.
`timescale 1ns / 1ps
`include "point_rotation_about_reference_unit_assert.svh"

module point_rotation_about_reference_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  prau_pkg::t_in_item  i_item,
    output logic                o_done,
    output prau_pkg::t_out_item o_result
);

    localparam int NSTG  = prau_pkg::STAGES;
    localparam int IDX_W = prau_pkg::STAGE_IDX_W;
    localparam int LAT   = prau_pkg::LATENCY;

    logic                accept;
    prau_pkg::t_cell_bus chain [NSTG+1];

    // Every stage advances each cycle, so the block never holds off start.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Subtract the pivot, take out whole quarter turns, form residual angle.
    prau_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .o_bus   (chain[0])
    );

    // Row of micro-rotation cells; each hands its item to the next one.
    for (genvar g = 0; g < NSTG; g++) begin : g_cell
        prau_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (IDX_W'(g)),
            .i_bus   (chain[g]),
            .o_bus   (chain[g+1])
        );
    end

    // Remove CORDIC gain, add pivot back, round and saturate, register out.
    prau_gain u_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bus    (chain[NSTG]),
        .o_valid  (o_done),
        .o_result (o_result)
    );

    // Every accepted item comes out on o_done, and no result comes without an item.
    `PRAU_ASSERT_DELAY(a_lat_fwd, i_clk, i_rst_n, accept, LAT, o_done, "item lost in pipeline")
    `PRAU_ASSERT_IMPL(a_lat_back, i_clk, i_rst_n, o_done, $past(accept, LAT), "result without item")
    // A point on the pivot maps onto the pivot itself.
    `PRAU_ASSERT_DELAY(a_pivot_fixed, i_clk, i_rst_n, accept && i_item.point_x == i_item.pivot_x && i_item.point_y == i_item.pivot_y, LAT, o_result.rotated_x == $past(i_item.pivot_x, LAT) && o_result.rotated_y == $past(i_item.pivot_y, LAT) && !o_result.overflow, "pivot point moved")
    // Overflow only with a coordinate clamped to a range end.
    `PRAU_ASSERT_IMPL(a_ovf_sat, i_clk, i_rst_n, o_done && o_result.overflow, o_result.rotated_x == prau_pkg::COORD_MAX || o_result.rotated_x == prau_pkg::COORD_MIN || o_result.rotated_y == prau_pkg::COORD_MAX || o_result.rotated_y == prau_pkg::COORD_MIN, "overflow without clamp")

endmodule

// ----- rtl/core/prau_prep.sv -----
// Front stage: pivot subtraction, quarter-turn swap and residual angle.
// Depends on prau_pkg.
`timescale 1ns / 1ps

module prau_prep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  prau_pkg::t_in_item  i_item,
    output prau_pkg::t_cell_bus o_bus
);

    localparam int CW    = prau_pkg::COORD_WIDTH;
    localparam int AW    = prau_pkg::ANGLE_WIDTH;
    localparam int XW    = prau_pkg::XY_W;
    localparam int ZW    = prau_pkg::Z_W;
    localparam int GD    = prau_pkg::GUARD;
    localparam int EXT_W = XW - (CW + 1) - GD;

    logic signed [CW:0]                dx;
    logic signed [CW:0]                dy;
    logic signed [XW-1:0]              sx;
    logic signed [XW-1:0]              sy;
    logic        [AW-1:0]              a_adj;
    logic        [1:0]                 quad;
    logic signed [prau_pkg::R_W-1:0]   resid;
    prau_pkg::t_cell_bus               n_data;
    prau_pkg::t_cell_bus               r_data;
    logic                              r_valid;

    assign dx = {i_item.point_x[CW-1], i_item.point_x} - {i_item.pivot_x[CW-1], i_item.pivot_x};
    assign dy = {i_item.point_y[CW-1], i_item.point_y} - {i_item.pivot_y[CW-1], i_item.pivot_y};
    assign sx = {{EXT_W{dx[CW]}}, dx, {GD{1'b0}}};
    assign sy = {{EXT_W{dy[CW]}}, dy, {GD{1'b0}}};

    // Offset by an eighth turn so the residual is centered on the quadrant.
    assign a_adj = i_item.turn_angle + prau_pkg::EIGHTH;
    assign quad  = a_adj[AW-1 -: 2];
    assign resid = {~a_adj[AW-3], a_adj[AW-4:0]};

    always_comb begin
        n_data         = '0;
        n_data.valid   = i_valid;
        n_data.z       = ZW'(resid) * ZW'(signed'(prau_pkg::PI_Q30));
        n_data.pivot_x = i_item.pivot_x;
        n_data.pivot_y = i_item.pivot_y;
        case (quad)
            prau_pkg::QUAD_1: begin
                n_data.x = -sy;
                n_data.y = sx;
            end
            prau_pkg::QUAD_2: begin
                n_data.x = -sx;
                n_data.y = -sy;
            end
            prau_pkg::QUAD_3: begin
                n_data.x = sy;
                n_data.y = -sx;
            end
            default: begin
                n_data.x = sx;
                n_data.y = sy;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_comb begin
        o_bus       = r_data;
        o_bus.valid = r_valid;
    end

endmodule

// ----- rtl/core/prau_cell.sv -----
// One CORDIC micro-rotation cell of the rotation chain.
// Depends on prau_pkg (bus type, arctangent table).
`timescale 1ns / 1ps

module prau_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [prau_pkg::STAGE_IDX_W-1:0]    i_stage,
    input  prau_pkg::t_cell_bus                 i_bus,
    output prau_pkg::t_cell_bus                 o_bus
);

    logic signed [prau_pkg::XY_W-1:0] xs;
    logic signed [prau_pkg::XY_W-1:0] ys;
    logic signed [prau_pkg::Z_W-1:0]  step;
    prau_pkg::t_cell_bus              n_data;
    prau_pkg::t_cell_bus              r_data;
    logic                             r_valid;

    assign xs   = i_bus.x >>> i_stage;
    assign ys   = i_bus.y >>> i_stage;
    assign step = signed'(prau_pkg::ATAN_TAB[i_stage]);

    // Rotate toward zero residual angle; both updates use the old x and y.
    always_comb begin
        n_data = i_bus;
        if (!i_bus.z[prau_pkg::Z_W-1]) begin
            n_data.x = i_bus.x - ys;
            n_data.y = i_bus.y + xs;
            n_data.z = i_bus.z - step;
        end else begin
            n_data.x = i_bus.x + ys;
            n_data.y = i_bus.y - xs;
            n_data.z = i_bus.z + step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_comb begin
        o_bus       = r_data;
        o_bus.valid = r_valid;
    end

endmodule

// ----- rtl/core/prau_gain.sv -----
// Back end: inverse-gain multiply, pivot add, rounding and saturation.
// Depends on prau_pkg.
`timescale 1ns / 1ps

module prau_gain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prau_pkg::t_cell_bus i_bus,
    output logic                o_valid,
    output prau_pkg::t_out_item o_result
);

    localparam int NL    = 2;  // lane 0 is x, lane 1 is y
    localparam int CW    = prau_pkg::COORD_WIDTH;
    localparam int XW    = prau_pkg::XY_W;
    localparam int HW    = prau_pkg::HI_W;
    localparam int SW    = prau_pkg::SUM_W;
    localparam int GD    = prau_pkg::GUARD;
    localparam int EXT_W = SW - CW - GD;
    localparam logic [63:0]          HALF_Q31 = 64'd1 << 30;
    localparam logic signed [SW-1:0] HALF_LSB = SW'(1) << (GD - 1);

    logic signed [XW-1:0] in_v     [NL];
    logic signed [CW-1:0] in_p     [NL];
    logic                 r1_valid;
    logic                 r2_valid;
    logic                 r3_valid;
    logic                 r_valid;
    logic                 r1_neg   [NL];
    logic                 r2_neg   [NL];
    logic [XW-1:0]        n1_mag   [NL];
    logic [XW-1:0]        r1_mag   [NL];
    logic signed [CW-1:0] r1_piv   [NL];
    logic signed [CW-1:0] r2_piv   [NL];
    logic signed [CW-1:0] r3_piv   [NL];
    logic [HW+31:0]       n2_hi    [NL];
    logic [HW+31:0]       r2_hi    [NL];
    logic [63:0]          n2_lo    [NL];
    logic [63:0]          r2_lo    [NL];
    logic [63:0]          lo_rnd   [NL];
    logic [SW-1:0]        mag3     [NL];
    logic signed [SW-1:0] n3_v     [NL];
    logic signed [SW-1:0] r3_v     [NL];
    logic signed [SW-1:0] piv_s    [NL];
    logic signed [SW-1:0] tot      [NL];
    logic signed [CW-1:0] sat_v    [NL];
    logic                 sat_hit  [NL];
    prau_pkg::t_out_item  n_result;
    prau_pkg::t_out_item  r_result;

    assign in_v[0] = i_bus.x;
    assign in_v[1] = i_bus.y;
    assign in_p[0] = i_bus.pivot_x;
    assign in_p[1] = i_bus.pivot_y;

    // Sign-magnitude split, two narrow partial products per lane, then recombine, round and restore the sign.
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            n1_mag[l] = in_v[l][XW-1] ? XW'(-in_v[l]) : XW'(in_v[l]);
            n2_hi[l]  = (HW+32)'(r1_mag[l][XW-1:32]) * (HW+32)'(prau_pkg::KINV);
            n2_lo[l]  = 64'(r1_mag[l][31:0]) * 64'(prau_pkg::KINV);
            lo_rnd[l] = r2_lo[l] + HALF_Q31;
            mag3[l]   = {r2_hi[l], 1'b0} + SW'(lo_rnd[l][63:31]);
            n3_v[l]   = r2_neg[l] ? -signed'(mag3[l]) : signed'(mag3[l]);
        end
    end

    // Add pivot back, round half up, clamp to the coordinate range.
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            piv_s[l]   = {{EXT_W{r3_piv[l][CW-1]}}, r3_piv[l], {GD{1'b0}}};
            tot[l]     = r3_v[l] + piv_s[l] + HALF_LSB;
            sat_hit[l] = !((&tot[l][SW-1:GD+CW-1]) || !(|tot[l][SW-1:GD+CW-1]));
            if (!sat_hit[l]) begin
                sat_v[l] = tot[l][GD+CW-1:GD];
            end else if (tot[l][SW-1]) begin
                sat_v[l] = prau_pkg::COORD_MIN;
            end else begin
                sat_v[l] = prau_pkg::COORD_MAX;
            end
        end
        n_result.rotated_x = sat_v[0];
        n_result.rotated_y = sat_v[1];
        n_result.overflow  = sat_hit[0] || sat_hit[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r1_valid <= i_bus.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r_valid  <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            r1_neg[l] <= in_v[l][XW-1];
            r1_mag[l] <= n1_mag[l];
            r1_piv[l] <= in_p[l];
            r2_neg[l] <= r1_neg[l];
            r2_hi[l]  <= n2_hi[l];
            r2_lo[l]  <= n2_lo[l];
            r2_piv[l] <= r1_piv[l];
            r3_v[l]   <= n3_v[l];
            r3_piv[l] <= r2_piv[l];
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- tb/sv/point_rotation_about_reference_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for point_rotation_about_reference_unit: directed corner items, then
// random items with random idle gaps, each result checked against a bit-exact predictor.
// Depends on prau_pkg and the unit itself.

module point_rotation_about_reference_unit_tb;
    import prau_pkg::*;

    localparam int     RESET_CYCLES  = 8;
    localparam int     RANDOM_ITEMS  = 400;
    localparam int     MAX_GAP       = 15;
    localparam int     STRETCH_ITEMS = 24;
    localparam int     DRAIN_LIMIT   = 2000;
    localparam int     TIMEOUT_NS    = 300000;
    // Differences carry this many guard bits through the rotation.
    localparam int     SCALE_BITS    = 58 - COORD_WIDTH;
    localparam int     QUARTER_TURN  = 1 << (ANGLE_WIDTH - 2);
    localparam int     EIGHTH_TURN   = 1 << (ANGLE_WIDTH - 3);
    localparam int     ONE_UNIT      = 256;
    localparam logic [63:0] PI_Q60_VAL = 64'h3243_F6A8_885A_308D;
    localparam longint      PI_Q30_VAL = 64'h0000_0000_C90F_DAA2;

    // Scoreboard: predicts the rotated point of every accepted item and checks results
    // in order against those predictions.
    class rotation_scoreboard;
        t_out_item       expected_q[$];
        int              errors;
        longint          atan_step[STAGES];
        longint unsigned inv_gain;

        function new();
            longint unsigned gain_sq;
            longint unsigned root;
            errors  = 0;
            for (int i = 0; i < STAGES; i++) begin
                atan_step[i] = arctan_q61(i) >>> (32 - ANGLE_WIDTH);
            end
            // K squared in Q60, then K in Q30 and 1/K in Q31, rounded.
            gain_sq = 64'd1 << 60;
            for (int i = 0; i < STAGES; i++) begin
                gain_sq = gain_sq + (gain_sq >> (2 * i));
            end
            root     = floor_sqrt(gain_sq);
            inv_gain = ((64'd1 << 61) + (root >> 1)) / root;
        endfunction

        function longint arctan_q61(int i);
            longint          acc;
            longint unsigned term;
            acc = 0;
            if (i == 0) begin
                return longint'(PI_Q60_VAL >> 1);
            end
            // Odd power series, each term truncated.
            for (int k = 0; i * (2 * k + 1) <= 61; k++) begin
                term = (64'd1 << (61 - i * (2 * k + 1))) / 64'(2 * k + 1);
                if (k % 2 != 0) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            return acc;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned n);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= n) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        // Multiply by 1/K in Q31, round half away from zero.
        function longint remove_gain(longint v);
            longint unsigned mag;
            logic [127:0]    prod;
            logic [127:0]    rounded;
            mag     = (v < 0) ? -v : v;
            prod    = 128'(mag) * 128'(inv_gain);
            rounded = (prod + (128'd1 << 30)) >> 31;
            return (v < 0) ? -longint'(rounded[63:0]) : longint'(rounded[63:0]);
        endfunction

        // Add the pivot back, drop guard bits rounding half up, clamp to the coordinate range.
        function logic signed [COORD_WIDTH-1:0] settle(longint v, longint pivot, inout logic sat);
            longint lim_hi;
            longint lim_lo;
            longint r;
            lim_hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
            lim_lo = -lim_hi - 1;
            r = (v + pivot * (longint'(1) << SCALE_BITS) + (longint'(1) << (SCALE_BITS - 1)))
                >>> SCALE_BITS;
            if (r > lim_hi) begin
                sat = 1'b1;
                return lim_hi[COORD_WIDTH-1:0];
            end
            if (r < lim_lo) begin
                sat = 1'b1;
                return lim_lo[COORD_WIDTH-1:0];
            end
            return r[COORD_WIDTH-1:0];
        endfunction

        function t_out_item rotate_about_pivot(t_in_item item);
            t_out_item   res;
            longint      px, py, rx, ry, dx, dy, x, y, xs, ys, z, resid;
            int unsigned shifted;
            logic [1:0]  quad;
            logic        sat;
            px = item.point_x;
            py = item.point_y;
            rx = item.pivot_x;
            ry = item.pivot_y;
            // Split the angle into whole quarter turns and a residual within an eighth.
            shifted = item.turn_angle + EIGHTH_TURN;
            quad    = 2'((shifted >> (ANGLE_WIDTH - 2)) & 3);
            resid   = longint'(shifted & (QUARTER_TURN - 1)) - EIGHTH_TURN;
            z       = resid * PI_Q30_VAL;
            dx      = (px - rx) * (longint'(1) << SCALE_BITS);
            dy      = (py - ry) * (longint'(1) << SCALE_BITS);
            case (quad)
                QUAD_1: begin
                    x = -dy;
                    y = dx;
                end
                QUAD_2: begin
                    x = -dx;
                    y = -dy;
                end
                QUAD_3: begin
                    x = dy;
                    y = -dx;
                end
                default: begin
                    x = dx;
                    y = dy;
                end
            endcase
            for (int i = 0; i < STAGES; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_step[i];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_step[i];
                end
            end
            sat           = 1'b0;
            res.rotated_x = settle(remove_gain(x), rx, sat);
            res.rotated_y = settle(remove_gain(y), ry, sat);
            res.overflow  = sat;
            return res;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        function void note_item(t_in_item item);
            expected_q.push_back(rotate_about_pivot(item));
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result x=%0d y=%0d ovf=%0b",
                                 got.rotated_x, got.rotated_y, got.overflow));
                return;
            end
            want = expected_q.pop_front();
            if (got.rotated_x !== want.rotated_x) begin
                report($sformatf("rotated_x got %0d want %0d", got.rotated_x, want.rotated_x));
            end
            if (got.rotated_y !== want.rotated_y) begin
                report($sformatf("rotated_y got %0d want %0d", got.rotated_y, want.rotated_y));
            end
            if (got.overflow !== want.overflow) begin
                report($sformatf("overflow got %0b want %0b", got.overflow, want.overflow));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        task check_drained();
            if (expected_q.size() != 0) begin
                report($sformatf("%0d results never arrived", expected_q.size()));
                errors += expected_q.size() - 1;
            end
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_done;
    t_out_item o_result;

    rotation_scoreboard sb = new();

    // When set, the sender runs back to back with no idle cycles.
    logic quiet_stretch;

    point_rotation_about_reference_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watch the handshakes at the rising edge: note every accepted item and check every
    // result strobe. Inputs move only at falling edges, so these samples are stable.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_item(i_item);
            end
            if (o_done) begin
                sb.check_result(o_result);
            end
        end
    end

    // Hold the item on the ports until the unit takes it; idle a random number of
    // cycles first unless in a back-to-back stretch. Start stays high only between items with no gap.
    task automatic send_item(t_in_item item);
        int gap;
        gap = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start  = 1'b1;
        i_item = item;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_coords(int px, int py, int rx, int ry, int unsigned ang);
        t_in_item it;
        it.point_x    = COORD_WIDTH'(px);
        it.point_y    = COORD_WIDTH'(py);
        it.pivot_x    = COORD_WIDTH'(rx);
        it.pivot_y    = COORD_WIDTH'(ry);
        it.turn_angle = ANGLE_WIDTH'(ang);
        send_item(it);
    endtask

    // Bias coordinates toward the ends of the range and toward small values.
    function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2, 3, 4: return COORD_WIDTH'(int'($urandom_range(0, 8191)) - 4096);
            default: return COORD_WIDTH'($urandom());
        endcase
    endfunction

    // Favor angles near whole quarter turns and near the quadrant split points.
    function automatic logic [ANGLE_WIDTH-1:0] pick_angle();
        case ($urandom_range(0, 5))
            0, 1: begin
                return ANGLE_WIDTH'(int'($urandom_range(0, 3)) * QUARTER_TURN
                                    + int'($urandom_range(0, 16)) - 8);
            end
            2: begin
                return ANGLE_WIDTH'((2 * int'($urandom_range(0, 3)) + 1) * EIGHTH_TURN
                                    + int'($urandom_range(0, 4)) - 2);
            end
            default: return ANGLE_WIDTH'($urandom_range(0, (1 << ANGLE_WIDTH) - 1));
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        if ($urandom_range(0, 3) == 0) begin
            it.pivot_x = '0;
            it.pivot_y = '0;
        end else begin
            it.pivot_x = pick_coord();
            it.pivot_y = pick_coord();
        end
        // Half the points sit near the pivot, the rest anywhere.
        if ($urandom_range(0, 1) == 0) begin
            it.point_x = it.pivot_x + COORD_WIDTH'(int'($urandom_range(0, 4095)) - 2048);
            it.point_y = it.pivot_y + COORD_WIDTH'(int'($urandom_range(0, 4095)) - 2048);
        end else begin
            it.point_x = pick_coord();
            it.point_y = pick_coord();
        end
        it.turn_angle = pick_angle();
        return it;
    endfunction

    task automatic run_directed();
        // Unit vector through every quarter turn and across the quadrant split points.
        send_coords(ONE_UNIT, 0, 0, 0, 0);
        send_coords(ONE_UNIT, 0, 0, 0, QUARTER_TURN);
        send_coords(ONE_UNIT, 0, 0, 0, 2 * QUARTER_TURN);
        send_coords(ONE_UNIT, 0, 0, 0, 3 * QUARTER_TURN);
        send_coords(ONE_UNIT, 0, 0, 0, EIGHTH_TURN);
        send_coords(ONE_UNIT, 0, 0, 0, EIGHTH_TURN - 1);
        send_coords(ONE_UNIT, 0, 0, 0, 7 * EIGHTH_TURN);
        send_coords(ONE_UNIT, 0, 0, 0, (1 << ANGLE_WIDTH) - 1);
        send_coords(1, -1, 0, 0, 1);
        // Point on the pivot, and a small offset about a nonzero pivot.
        send_coords(1000, -2000, 1000, -2000, 16'h1234);
        send_coords(512, 768, ONE_UNIT, -ONE_UNIT, QUARTER_TURN);
        send_coords(-1, -1, 1, 1, 16'h9ABC);
        // Range ends: exact passes and saturation on both sides.
        send_coords(COORD_MAX, COORD_MAX, 0, 0, 0);
        send_coords(COORD_MIN, COORD_MIN, 0, 0, 2 * QUARTER_TURN);
        send_coords(COORD_MAX, 0, COORD_MIN, 0, 0);
        send_coords(COORD_MAX, 0, COORD_MIN, 0, 2 * QUARTER_TURN);
        send_coords(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, QUARTER_TURN);
        send_coords(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, EIGHTH_TURN);
        send_coords(0, 0, COORD_MAX, COORD_MAX, 3 * EIGHTH_TURN);
        send_coords(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, (1 << ANGLE_WIDTH) - 1);
        send_coords(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 2 * QUARTER_TURN);
        send_coords(COORD_MIN, 0, 0, 0, QUARTER_TURN);
        send_coords(COORD_MIN, 0, 0, 0, 3 * QUARTER_TURN);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_item        = '0;
        quiet_stretch = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();

        // Switch between gapped and back-to-back stretches now and then.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % STRETCH_ITEMS == 0) begin
                quiet_stretch = ($urandom_range(0, 3) == 0);
            end
            send_item(random_item());
        end
        @(negedge i_clk);
        start = 1'b0;

        // Drain: wait for every prediction to be matched, then a pipeline's worth more.
        for (int c = 0; c < DRAIN_LIMIT && sb.pending() > 0; c++) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        sb.check_drained();

        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
